// ===== rtl/core/markup_code_stripper_macros.svh =====
// Assertion macros shared by the stripper modules.
`ifndef MARKUP_CODE_STRIPPER_MACROS_SVH
`define MARKUP_CODE_STRIPPER_MACROS_SVH

// Condition holds in the same cycle as its cause.
`define MCS_ASSERT_NOW(lbl, clk, rst_n, cause, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (cond)) \
		else $error("stripper check failed in the same cycle");

// Condition holds in the cycle after its cause.
`define MCS_ASSERT_NEXT(lbl, clk, rst_n, cause, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cond)) \
		else $error("stripper check failed one cycle later");

`endif

// ===== rtl/core/mcs_pkg.sv =====
package mcs_pkg;

	// Characters that the parser looks at.
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_C_LO  = 8'h63;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_B_LO  = 8'h62;
	localparam logic [7:0] CH_I_LO  = 8'h69;
	localparam logic [7:0] CH_R_LO  = 8'h72;
	localparam logic [7:0] CH_O_LO  = 8'h6F;
	localparam logic [7:0] CH_C_UP  = 8'h43;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_B_UP  = 8'h42;
	localparam logic [7:0] CH_I_UP  = 8'h49;

	// Bytes dropped after the color, alpha and flash codes.
	localparam logic [2:0] SKIP_COLOR = 3'd6;
	localparam logic [2:0] SKIP_ALPHA = 3'd2;
	localparam logic [2:0] SKIP_FLASH = 3'd1;

	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_CARET = 2'd1,
		MODE_SKIP  = 2'd2
	} mode_t;

	// One input word.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	// One output word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       run_last;
	} res_t;

	// All output words caused by one input word, in order.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} pair_t;

endpackage

// ===== rtl/core/mcs_in_if.sv =====
interface mcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/mcs_out_if.sv =====
interface mcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_end;
	logic       run_last;

	modport source (output valid, output out_byte, output byte_valid, output string_end,
		output run_last, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input string_end,
		input run_last, output ready);
endinterface

// ===== rtl/core/mcs_in_stage.sv =====
module mcs_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	mcs_in_if.sink             chars,
	input  logic               advance,
	output logic               valid_s1,
	output mcs_pkg::item_t     item_s1
);
	import mcs_pkg::*;

	// The register takes a new word when it is empty or its word moves on.
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1 <= '{in_byte: chars.in_byte, in_last: chars.in_last};
		end
	end
endmodule

// ===== rtl/core/mcs_parser.sv =====
module mcs_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mcs_pkg::item_t     item,
	output mcs_pkg::pair_t     pair
);
	import mcs_pkg::*;
	`include "markup_code_stripper_macros.svh"

	mode_t      mode_q;
	mode_t      mode_d;
	logic [2:0] skip_q;
	logic [2:0] skip_d;
	logic [2:0] skip_dec;

	assign skip_dec = (skip_q != 3'd0) ? skip_q - 3'd1 : 3'd0;

	// Next parse mode and drop count.
	always_comb begin
		mode_d = mode_q;
		skip_d = skip_q;
		unique case (mode_q)
			MODE_CARET: begin
				mode_d = MODE_TEXT;
				unique case (item.in_byte)
					CH_C_LO: begin
						mode_d = MODE_SKIP;
						skip_d = SKIP_COLOR;
					end
					CH_A_LO: begin
						mode_d = MODE_SKIP;
						skip_d = SKIP_ALPHA;
					end
					CH_F_LO: begin
						mode_d = MODE_SKIP;
						skip_d = SKIP_FLASH;
					end
					default: begin
						mode_d = MODE_TEXT;
					end
				endcase
			end
			MODE_SKIP: begin
				skip_d = skip_dec;
				mode_d = (skip_dec == 3'd0) ? MODE_TEXT : MODE_SKIP;
			end
			default: begin
				mode_d = (item.in_byte == CH_CARET && !item.in_last) ? MODE_CARET : MODE_TEXT;
			end
		endcase
		// The end of a string abandons any code in progress.
		if (item.in_last) begin
			mode_d = MODE_TEXT;
			skip_d = 3'd0;
		end
	end

	// Output words for the current input word.
	always_comb begin
		pair = '0;
		unique case (mode_q)
			MODE_CARET: begin
				unique case (item.in_byte)
					CH_C_LO, CH_A_LO, CH_F_LO, CH_B_LO, CH_I_LO, CH_R_LO, CH_O_LO,
					CH_C_UP, CH_A_UP, CH_F_UP, CH_B_UP, CH_I_UP: begin
						pair.n = 2'd0;
					end
					CH_CARET: begin
						pair.n = 2'd1;
						pair.r0 = '{out_byte: CH_CARET, byte_valid: 1'b1,
							string_end: item.in_last, run_last: 1'b1};
					end
					default: begin
						pair.n = 2'd2;
						pair.r0 = '{out_byte: CH_CARET, byte_valid: 1'b1,
							string_end: 1'b0, run_last: 1'b0};
						pair.r1 = '{out_byte: item.in_byte, byte_valid: 1'b1,
							string_end: item.in_last, run_last: 1'b1};
					end
				endcase
			end
			MODE_SKIP: begin
				pair.n = 2'd0;
			end
			default: begin
				if (!(item.in_byte == CH_CARET && !item.in_last)) begin
					pair.n = 2'd1;
					pair.r0 = '{out_byte: item.in_byte, byte_valid: 1'b1,
						string_end: item.in_last, run_last: 1'b1};
				end
			end
		endcase
		// A string that ends with nothing to show still gets an end word.
		if (pair.n == 2'd0 && item.in_last) begin
			pair.n = 2'd1;
			pair.r0 = '{out_byte: 8'h00, byte_valid: 1'b0, string_end: 1'b1, run_last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			skip_q <= 3'd0;
		end else if (step) begin
			mode_q <= mode_d;
			skip_q <= skip_d;
		end
	end

	`MCS_ASSERT_NOW(a_skip_nonzero, clk, arst_n, mode_q == MODE_SKIP, skip_q != 3'd0)
	`MCS_ASSERT_NEXT(a_last_resets, clk, arst_n, step && item.in_last,
		mode_q == MODE_TEXT && skip_q == 3'd0)
	`MCS_ASSERT_NOW(a_pair_caret, clk, arst_n, step && pair.n == 2'd2,
		pair.r0.out_byte == CH_CARET && !pair.r0.run_last && pair.r1.run_last)
endmodule

// ===== rtl/core/mcs_res_buf.sv =====
module mcs_res_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  mcs_pkg::pair_t     pair,
	output logic               load_ok,
	mcs_out_if.source          stripped
);
	import mcs_pkg::*;
	`include "markup_code_stripper_macros.svh"

	logic [1:0] cnt_q;
	res_t       slot_q [2];
	logic       pop;

	// The head slot drives the output channel.
	assign stripped.valid      = cnt_q != 2'd0;
	assign stripped.out_byte   = slot_q[0].out_byte;
	assign stripped.byte_valid = slot_q[0].byte_valid;
	assign stripped.string_end = slot_q[0].string_end;
	assign stripped.run_last   = slot_q[0].run_last;

	assign pop     = stripped.valid && stripped.ready;
	assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// A new pair replaces the emptied buffer; otherwise the second word moves up.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= pair.r0;
			slot_q[1] <= pair.r1;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

	`MCS_ASSERT_NOW(a_full_blocks, clk, arst_n, cnt_q == 2'd2, !load_ok)
	`MCS_ASSERT_NEXT(a_drain_one, clk, arst_n, pop && cnt_q == 2'd2 && !load, cnt_q == 2'd1)
	`MCS_ASSERT_NOW(a_head_not_final, clk, arst_n, cnt_q == 2'd2, !slot_q[0].run_last)
endmodule

// ===== rtl/core/markup_code_stripper.sv =====
// Markup code stripper.
// The chars channel carries one character of a decorated string per
// word, with in_last set on the final character. The stripped channel returns
// the string with its caret codes removed: each word holds out_byte, with
// byte_valid telling whether it carries a character, string_end on the word
// that closes the string and run_last on the last word caused by an input.
// An accepted input is registered in the input register, decoded, and loaded
// into the result register once that has room; its first word is offered
// from there. Throughput is one character per cycle while the receiver keeps
// up; a caret followed by an ordinary character yields two words, and the
// two-entry result register then holds the input side while both wait. Dropped
// characters give no word and still move at one per cycle.
// Reset empties the input and result registers and puts the parser in plain
// text mode with no drop pending. When the receiver stalls, words wait in the
// result register; one more input waits in the input register, after which
// chars.ready stays low until the receiver takes the last waiting word.
module markup_code_stripper (
	input  logic       clk,
	input  logic       arst_n,
	mcs_in_if.sink     chars,
	mcs_out_if.source  stripped
);
	import mcs_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  load_ok;
	logic  step;
	pair_t pair;

	assign step = valid_s1 && load_ok;

	mcs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mcs_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.pair   (pair)
	);

	mcs_res_buf u_res_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.pair     (pair),
		.load_ok  (load_ok),
		.stripped (stripped)
	);
endmodule

// ===== sim/tb_markup_code_stripper.sv =====
module tb_markup_code_stripper;
	timeunit 1ns;
	timeprecision 1ps;

	import mcs_pkg::*;

	localparam int ITEM_TARGET = 1600;
	localparam int CALM_TAIL   = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam res_t NO_WORD   = '0;

	// One row of the directed stimulus; typed rows carry their own expected words.
	typedef struct {
		logic [7:0] ch;
		logic       last;
		bit         typed;
		int         n;
		res_t       w0;
		res_t       w1;
	} dir_row_t;

	logic clk;
	logic arst_n;

	mcs_in_if  chars_if();
	mcs_out_if stripped_if();

	markup_code_stripper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.stripped (stripped_if)
	);

	// Parser state as the predictor sees it.
	mode_t      parse_st;
	logic [2:0] drop_left;

	// Words still owed by the block, oldest first.
	res_t stripped_due[$];

	// Characters of the string being sent.
	logic [7:0] text_q[$];

	bit calm;
	int cyc_count;
	int n_bad;
	int n_strings;
	int n_chars;
	int n_words;
	int n_pairs;
	int n_dropped;

	dir_row_t dir_rows [26] = '{
		'{8'h48, 1'b0, 1'b1, 1, '{8'h48, 1'b1, 1'b0, 1'b1}, NO_WORD},
		'{8'h01, 1'b0, 1'b1, 1, '{8'h01, 1'b1, 1'b0, 1'b1}, NO_WORD},
		'{8'hFF, 1'b0, 1'b1, 1, '{8'hFF, 1'b1, 1'b0, 1'b1}, NO_WORD},
		'{8'h00, 1'b0, 1'b1, 1, '{8'h00, 1'b1, 1'b0, 1'b1}, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_C_LO,  1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h31,    1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h32,    1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_CARET, 1'b0, 1'b1, 1, '{CH_CARET, 1'b1, 1'b0, 1'b1}, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_A_LO,  1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h78,    1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h79,    1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h7A,    1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_F_LO,  1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h71,    1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_B_UP,  1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{8'h6B, 1'b1, 1'b1, 2, '{CH_CARET, 1'b1, 1'b0, 1'b0}, '{8'h6B, 1'b1, 1'b1, 1'b1}},
		'{CH_CARET, 1'b1, 1'b1, 1, '{CH_CARET, 1'b1, 1'b1, 1'b1}, NO_WORD},
		'{8'h62,    1'b1, 1'b1, 1, '{8'h62, 1'b1, 1'b1, 1'b1}, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, 0, NO_WORD, NO_WORD},
		'{CH_I_UP,  1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, NO_WORD}
	};

	// Free-running clock.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Predict the words that one character produces and advance the parser state.
	task automatic predict_strip(input logic [7:0] ch, input logic last, output int n,
		output res_t w0, output res_t w1);
		bit         single;
		logic [7:0] put_ch;
		n      = 0;
		w0     = NO_WORD;
		w1     = NO_WORD;
		single = 1'b0;
		put_ch = ch;
		case (parse_st)
			MODE_CARET: begin
				parse_st = MODE_TEXT;
				case (ch)
					CH_C_LO: begin
						parse_st  = MODE_SKIP;
						drop_left = SKIP_COLOR;
					end
					CH_A_LO: begin
						parse_st  = MODE_SKIP;
						drop_left = SKIP_ALPHA;
					end
					CH_F_LO: begin
						parse_st  = MODE_SKIP;
						drop_left = SKIP_FLASH;
					end
					// Style codes vanish together with their caret.
					CH_B_LO, CH_I_LO, CH_R_LO, CH_O_LO,
					CH_C_UP, CH_A_UP, CH_F_UP, CH_B_UP, CH_I_UP: ;
					CH_CARET: begin
						single = 1'b1;
						put_ch = CH_CARET;
					end
					default: begin
						w0 = '{CH_CARET, 1'b1, 1'b0, 1'b0};
						w1 = '{ch, 1'b1, last, 1'b1};
						n  = 2;
					end
				endcase
			end
			MODE_SKIP: begin
				if (drop_left != 3'd0)
					drop_left = drop_left - 3'd1;
				if (drop_left == 3'd0)
					parse_st = MODE_TEXT;
			end
			default: begin
				if (ch == CH_CARET && !last) begin
					parse_st = MODE_CARET;
				end else begin
					parse_st = MODE_TEXT;
					single   = 1'b1;
				end
			end
		endcase

		// A string always closes with a word, even when nothing is left to show.
		if (single) begin
			w0 = '{put_ch, 1'b1, last, 1'b1};
			n  = 1;
		end else if (n == 0 && last) begin
			w0 = '{8'h00, 1'b0, 1'b1, 1'b1};
			n  = 1;
		end

		if (last) begin
			parse_st  = MODE_TEXT;
			drop_left = 3'd0;
		end
	endtask

	// Offer one character, wait for it to be taken, and book the words it owes.
	task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
		input int tn, input res_t t0, input res_t t1);
		int   gap;
		int   pn;
		res_t p0;
		res_t p1;
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			chars_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.in_byte <= ch;
		chars_if.in_last <= last;
		do @(posedge clk); while (chars_if.ready !== 1'b1);

		predict_strip(ch, last, pn, p0, p1);
		if (typed) begin
			pn = tn;
			p0 = t0;
			p1 = t1;
		end
		if (pn > 0)
			stripped_due.push_back(p0);
		if (pn > 1)
			stripped_due.push_back(p1);
		n_chars++;
		if (pn == 2)
			n_pairs++;
		if (pn == 0)
			n_dropped++;
		if (last)
			n_strings++;
	endtask

	// Hold the input side until every owed word has come out.
	task automatic drain_output();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (stripped_due.size() != 0) @(posedge clk);
	endtask

	function automatic bit is_markup_letter(input logic [7:0] ch);
		case (ch)
			CH_C_LO, CH_A_LO, CH_F_LO, CH_B_LO, CH_I_LO, CH_R_LO, CH_O_LO,
			CH_C_UP, CH_A_UP, CH_F_UP, CH_B_UP, CH_I_UP: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] style_letter(input int idx);
		case (idx)
			0: return CH_B_LO;
			1: return CH_I_LO;
			2: return CH_R_LO;
			3: return CH_O_LO;
			4: return CH_C_UP;
			5: return CH_A_UP;
			6: return CH_F_UP;
			7: return CH_B_UP;
			default: return CH_I_UP;
		endcase
	endfunction

	// Any nonzero character that is not a caret.
	function automatic logic [7:0] text_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(1, 255));
		while (ch == CH_CARET)
			ch = 8'($urandom_range(1, 255));
		return ch;
	endfunction

	// A character that a caret does not turn into a code; now and then a zero.
	function automatic logic [7:0] plain_follower();
		logic [7:0] ch;
		if ($urandom_range(0, 31) == 0)
			return 8'h00;
		ch = text_char();
		while (is_markup_letter(ch))
			ch = text_char();
		return ch;
	endfunction

	// Build one string from text runs and codes, sometimes broken off early.
	task automatic build_text();
		int pieces;
		int cut;
		text_q = {};
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 10))
				0, 1, 2: repeat ($urandom_range(1, 4)) text_q.push_back(text_char());
				3: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(CH_C_LO);
					repeat (6) text_q.push_back(8'($urandom_range(1, 255)));
				end
				4: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(CH_A_LO);
					repeat (2) text_q.push_back(8'($urandom_range(1, 255)));
				end
				5: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(CH_F_LO);
					text_q.push_back(8'($urandom_range(1, 255)));
				end
				6: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(style_letter($urandom_range(0, 8)));
				end
				7: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(CH_CARET);
				end
				8: begin
					text_q.push_back(CH_CARET);
					text_q.push_back(plain_follower());
				end
				9: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
				default: text_q.push_back(CH_CARET);
			endcase
		end

		// Breaking off lets strings end inside a code or right after a caret.
		if ($urandom_range(0, 3) == 0) begin
			cut = $urandom_range(1, text_q.size());
			while (text_q.size() > cut)
				void'(text_q.pop_back());
		end
		if ($urandom_range(0, 7) == 0)
			text_q.push_back(CH_CARET);
	endtask

	// Receiver: takes words with random stall bursts, none while calm.
	initial begin : receiver
		int stall;
		stripped_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7);
				stripped_if.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				stripped_if.ready <= 1'b1;
			end
		end
	end

	// Compare every word taken from the block with the oldest one owed.
	always @(posedge clk) begin : word_check
		res_t got;
		res_t want;
		if (arst_n && stripped_if.valid === 1'b1 && stripped_if.ready === 1'b1) begin
			got = '{stripped_if.out_byte, stripped_if.byte_valid, stripped_if.string_end,
				stripped_if.run_last};
			n_words++;
			if (stripped_due.size() == 0) begin
				n_bad++;
				if (n_bad <= REPORT_MAX)
					$display("%0t: word with none owed: out_byte %h valid %b end %b run_last %b",
						$realtime, got.out_byte, got.byte_valid, got.string_end, got.run_last);
			end else begin
				want = stripped_due.pop_front();
				if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
					got.string_end !== want.string_end || got.run_last !== want.run_last) begin
					n_bad++;
					if (n_bad <= REPORT_MAX)
						$display("%0t: word mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
							$realtime, want.out_byte, want.byte_valid, want.string_end,
							want.run_last, got.out_byte, got.byte_valid, got.string_end,
							got.run_last);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words still owed.",
				cyc_count, stripped_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random strings.
	initial begin : stimulus
		int r;
		int next_drain;
		arst_n           = 1'b0;
		chars_if.valid   = 1'b0;
		chars_if.in_byte = 8'h00;
		chars_if.in_last = 1'b0;
		parse_st         = MODE_TEXT;
		drop_left        = 3'd0;
		calm             = 1'b0;
		cyc_count        = 0;
		n_bad            = 0;
		n_strings        = 0;
		n_chars          = 0;
		n_words          = 0;
		n_pairs          = 0;
		n_dropped        = 0;
		next_drain       = 400;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < $size(dir_rows); r++)
			send_char(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].n,
				dir_rows[r].w0, dir_rows[r].w1);
		drain_output();

		// Random strings; every few hundred characters the input waits for the output.
		while (n_chars < ITEM_TARGET) begin
			calm = (n_chars > ITEM_TARGET - CALM_TAIL) || ($urandom_range(0, 5) == 0);
			build_text();
			for (r = 0; r < text_q.size(); r++)
				send_char(text_q[r], r == text_q.size() - 1, 1'b0, 0, NO_WORD, NO_WORD);
			if (n_chars >= next_drain) begin
				drain_output();
				next_drain += 400;
			end
		end

		drain_output();
		repeat (20) @(posedge clk);
		n_bad += stripped_due.size();

		$display("Sent %0d strings, %0d characters; %0d words checked.",
			n_strings, n_chars, n_words);
		$display("%0d characters gave two words, %0d were swallowed by codes or carets.",
			n_pairs, n_dropped);
		if (n_bad == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
